// ===== rtl/core/mvt_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mvt_pkg: shared types and constants
// Constants, request and status codes for the MAC/VLAN exact-match table.
// ----------------------------------------------------------------------------
package mvt_pkg;

    localparam int BUCKETS   = 256;
    localparam int ENTRIES   = 1024;
    localparam int BKT_W     = $clog2(BUCKETS);
    localparam int SLOT_W    = $clog2(ENTRIES);
    localparam int PTR_W     = SLOT_W + 1;
    localparam int CNT_W     = SLOT_W + 1;
    localparam int KEY_W     = 60;
    localparam int PORT_W    = 16;
    localparam int HASH_W    = 48;
    localparam int DIV_W     = 9;
    localparam int LIM_W     = 11;
    localparam int VLAN_SHIFT = 32;

    localparam logic [PTR_W-1:0] NIL_SLOT = PTR_W'(ENTRIES);

    localparam logic [1:0] REQ_LOOKUP = 2'd0;
    localparam logic [1:0] REQ_ADD    = 2'd1;
    localparam logic [1:0] REQ_DEL    = 2'd2;
    localparam logic [1:0] REQ_CLEAR  = 2'd3;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_FULL = 2'd1;
    localparam logic [1:0] ST_MISS = 2'd2;

    localparam logic CFG_BUCKETS = 1'b0;
    localparam logic CFG_LIMIT   = 1'b1;

    // modulo unit handshake
    typedef struct packed {
        logic              start;
        logic [HASH_W-1:0] dividend;
        logic [DIV_W-1:0]  divisor;
    } mod_req_t;

    typedef struct packed {
        logic             done;
        logic [BKT_W-1:0] rem;
    } mod_rsp_t;

endpackage
`default_nettype wire

// ===== rtl/core/mvt_mod.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mvt_mod: bucket hash modulo
// Restoring remainder, one dividend bit per cycle.
// ----------------------------------------------------------------------------
module mvt_mod
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire mvt_pkg::mod_req_t req,
    output mvt_pkg::mod_rsp_t      rsp
);
    import mvt_pkg::*;

    localparam int BIT_W = $clog2(HASH_W);

    logic [HASH_W-1:0] sh_reg, sh_next;
    logic [DIV_W:0]    rem_reg, rem_next;
    logic [DIV_W-1:0]  div_reg, div_next;
    logic [BIT_W-1:0]  bit_reg, bit_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [DIV_W:0]    trial;

    // shift in one bit, subtract when it fits
    always_comb
    begin
        sh_next   = sh_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        bit_next  = bit_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg[DIV_W-1:0], sh_reg[HASH_W-1]};
        if (req.start)
        begin
            sh_next   = req.dividend;
            rem_next  = '0;
            bit_next  = BIT_W'(HASH_W - 1);
            busy_next = 1'b1;
            if (req.divisor == '0)
                div_next = DIV_W'(1);
            else if (req.divisor > DIV_W'(BUCKETS))
                div_next = DIV_W'(BUCKETS);
            else
                div_next = req.divisor;
        end
        else if (busy_reg)
        begin
            sh_next = {sh_reg[HASH_W-2:0], 1'b0};
            if (trial >= {1'b0, div_reg})
                rem_next = trial - {1'b0, div_reg};
            else
                rem_next = trial;
            bit_next = bit_reg - BIT_W'(1);
            if (bit_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sh_reg  <= sh_next;
        rem_reg <= rem_next;
        div_reg <= div_next;
        bit_reg <= bit_next;
    end

    assign rsp.done = done_reg;
    assign rsp.rem  = rem_reg[BKT_W-1:0];

`ifndef SYNTHESIS
    a_rem_lt_div: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.done |-> ({1'b0, div_reg} > rem_reg))
        else $error("remainder not below divisor");
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.done |=> !rsp.done)
        else $error("done longer than one cycle");
`endif

endmodule
`default_nettype wire

// ===== rtl/core/mvt_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mvt_ctrl: table sequencer
// Holds heads, slot and free-list memories; walks chains and edits them.
// ----------------------------------------------------------------------------
module mvt_ctrl
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire logic [1:0]                   in_req,
    input  wire logic [mvt_pkg::KEY_W-1:0]    in_key,
    input  wire logic [mvt_pkg::PORT_W-1:0]   in_port,
    input  wire logic [mvt_pkg::DIV_W-1:0]    buckets_cfg,
    input  wire logic [mvt_pkg::LIM_W-1:0]    limit_cfg,
    output mvt_pkg::mod_req_t                 mod_req,
    input  wire mvt_pkg::mod_rsp_t            mod_rsp,
    output logic                              res_valid,
    input  wire logic                         res_ready,
    output logic [1:0]                        res_status,
    output logic [mvt_pkg::PORT_W-1:0]        res_port,
    output logic [mvt_pkg::CNT_W-1:0]         res_count
);
    import mvt_pkg::*;

    localparam logic [3:0] S_INIT  = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_HASH  = 4'd2;
    localparam logic [3:0] S_HEAD  = 4'd3;
    localparam logic [3:0] S_READ  = 4'd4;
    localparam logic [3:0] S_CMP   = 4'd5;
    localparam logic [3:0] S_FREE  = 4'd6;
    localparam logic [3:0] S_INS   = 4'd7;
    localparam logic [3:0] S_OUT   = 4'd8;
    localparam logic [3:0] S_FRDWT = 4'd9;

    // memories
    logic [PTR_W-1:0]  head_mem [BUCKETS];
    logic [KEY_W-1:0]  key_mem  [ENTRIES];
    logic [PORT_W-1:0] port_mem [ENTRIES];
    logic [PTR_W-1:0]  next_mem [ENTRIES];
    logic [SLOT_W-1:0] free_mem [ENTRIES];
    logic [BUCKETS-1:0] head_vld_reg;

    logic [3:0]        state_reg, state_next;
    logic [1:0]        req_reg;
    logic [KEY_W-1:0]  key_reg;
    logic [PORT_W-1:0] port_reg;
    logic [BKT_W-1:0]  bkt_reg;
    logic [PTR_W-1:0]  cur_reg, prev_reg;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [CNT_W-1:0]  steps_reg;
    logic [SLOT_W-1:0] init_reg;
    logic [1:0]        st_reg;
    logic [PORT_W-1:0] pout_reg;
    logic [CNT_W-1:0]  limit_c;

    // registered read data
    logic [PTR_W-1:0]  head_rd;
    logic              head_rd_vld;
    logic [KEY_W-1:0]  key_rd;
    logic [PORT_W-1:0] port_rd;
    logic [PTR_W-1:0]  next_rd;
    logic [SLOT_W-1:0] free_rd;

    // memory write strobes
    logic              head_we;
    logic [PTR_W-1:0]  head_wd;
    logic              next_we;
    logic [SLOT_W-1:0] next_wa;
    logic [PTR_W-1:0]  next_wd;
    logic              kp_we;
    logic              port_we;
    logic [SLOT_W-1:0] slot_wa;
    logic              free_we;
    logic [SLOT_W-1:0] free_wa, free_wd;
    logic              clr_all;
    logic [SLOT_W-1:0] rd_addr;
    logic [BKT_W-1:0]  head_ra;

    assign limit_c = (limit_cfg > LIM_W'(ENTRIES)) ? CNT_W'(ENTRIES) : CNT_W'(limit_cfg);
    assign rd_addr = cur_reg[SLOT_W-1:0];
    // head read follows the new bucket as soon as the hash is done
    assign head_ra = mod_rsp.done ? mod_rsp.rem : bkt_reg;

    always_comb
    begin
        state_next = state_reg;
        head_we = 1'b0; head_wd = cur_reg;
        next_we = 1'b0; next_wa = prev_reg[SLOT_W-1:0]; next_wd = next_rd;
        kp_we = 1'b0; port_we = 1'b0; slot_wa = rd_addr;
        free_we = 1'b0; free_wa = init_reg; free_wd = init_reg;
        clr_all = 1'b0;
        cnt_next = cnt_reg;
        unique case (state_reg)
            S_INIT:
            begin
                free_we = 1'b1;
                if (init_reg == SLOT_W'(ENTRIES - 1))
                    state_next = S_IDLE;
            end
            S_IDLE:
                if (in_valid)
                begin
                    if (in_req == REQ_CLEAR)
                    begin
                        // answer first, refill the free list afterwards
                        clr_all    = 1'b1;
                        cnt_next   = '0;
                        state_next = S_OUT;
                    end
                    else if (in_req == REQ_ADD && cnt_reg >= limit_c)
                        state_next = S_OUT;
                    else
                        state_next = S_HASH;
                end
            S_HASH:
                if (mod_rsp.done)
                    state_next = S_HEAD;
            S_HEAD:
                state_next = S_READ;
            S_READ:
                state_next = S_CMP;
            S_CMP:
            begin
                if (cur_reg >= NIL_SLOT || steps_reg >= CNT_W'(ENTRIES))
                begin
                    if (req_reg == REQ_ADD)
                        state_next = S_FREE;
                    else
                        state_next = S_OUT;
                end
                else if (key_rd == key_reg)
                begin
                    state_next = S_OUT;
                    if (req_reg == REQ_ADD)
                        port_we = 1'b1;
                    else if (req_reg == REQ_DEL)
                    begin
                        if (prev_reg < NIL_SLOT)
                            next_we = 1'b1;
                        else
                        begin
                            head_we = 1'b1;
                            head_wd = next_rd;
                        end
                        if (cnt_reg != '0)
                        begin
                            cnt_next = cnt_reg - CNT_W'(1);
                            free_we  = 1'b1;
                            free_wa  = cnt_next[SLOT_W-1:0];
                            free_wd  = rd_addr;
                        end
                    end
                end
                else
                    state_next = S_READ;
            end
            S_FREE:
                state_next = S_FRDWT;
            S_FRDWT:
                state_next = S_INS;
            S_INS:
            begin
                kp_we    = 1'b1;
                port_we  = 1'b1;
                slot_wa  = free_rd;
                next_we  = 1'b1;
                next_wa  = free_rd;
                next_wd  = head_rd_vld ? head_rd : NIL_SLOT;
                head_we  = 1'b1;
                head_wd  = {1'b0, free_rd};
                cnt_next = cnt_reg + CNT_W'(1);
                state_next = S_OUT;
            end
            S_OUT:
                if (res_ready)
                    state_next = (req_reg == REQ_CLEAR) ? S_INIT : S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_INIT;
            init_reg     <= '0;
            cnt_reg      <= '0;
            head_vld_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            if (state_reg == S_INIT)
                init_reg <= init_reg + SLOT_W'(1);
            if (clr_all)
                head_vld_reg <= '0;
            else if (head_we)
                head_vld_reg[bkt_reg] <= 1'b1;
        end
    end

    // request and walk registers
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && in_valid)
        begin
            req_reg  <= in_req;
            key_reg  <= in_key;
            port_reg <= in_port;
            pout_reg <= '0;
            st_reg   <= (in_req == REQ_ADD && cnt_reg >= limit_c) ? ST_FULL : ST_OK;
        end
        if (mod_rsp.done)
            bkt_reg <= mod_rsp.rem;
        if (state_reg == S_HEAD)
        begin
            cur_reg   <= head_vld_reg[bkt_reg] ? head_rd : NIL_SLOT;
            prev_reg  <= NIL_SLOT;
            steps_reg <= '0;
        end
        if (state_reg == S_CMP)
        begin
            if (cur_reg >= NIL_SLOT || steps_reg >= CNT_W'(ENTRIES))
            begin
                if (req_reg != REQ_ADD)
                    st_reg <= ST_MISS;
            end
            else if (key_rd == key_reg)
            begin
                if (req_reg == REQ_LOOKUP)
                    pout_reg <= port_rd;
            end
            else
            begin
                prev_reg  <= cur_reg;
                cur_reg   <= next_rd;
                steps_reg <= steps_reg + CNT_W'(1);
            end
        end
    end

    // head memory
    always_ff @(posedge clk)
    begin
        if (head_we)
            head_mem[bkt_reg] <= head_wd;
        head_rd     <= head_mem[head_ra];
        head_rd_vld <= head_vld_reg[head_ra];
    end

    // slot memories
    always_ff @(posedge clk)
    begin
        if (kp_we)
            key_mem[slot_wa] <= key_reg;
        if (port_we)
            port_mem[slot_wa] <= port_reg;
        if (next_we)
            next_mem[next_wa] <= next_wd;
        key_rd  <= key_mem[rd_addr];
        port_rd <= port_mem[rd_addr];
        next_rd <= next_mem[rd_addr];
    end

    // free list
    always_ff @(posedge clk)
    begin
        if (free_we)
            free_mem[free_wa] <= free_wd;
        free_rd <= free_mem[cnt_reg[SLOT_W-1:0]];
    end

    assign in_ready         = (state_reg == S_IDLE);
    assign mod_req.start    = (state_reg == S_IDLE) && in_valid && (in_req != REQ_CLEAR);
    assign mod_req.dividend = in_key[HASH_W-1:0]
                            ^ (HASH_W'(in_key[KEY_W-1:HASH_W]) << VLAN_SHIFT);
    assign mod_req.divisor  = buckets_cfg;
    assign res_valid        = (state_reg == S_OUT);
    assign res_status       = st_reg;
    assign res_port         = pout_reg;
    assign res_count        = cnt_reg;

`ifndef SYNTHESIS
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(ENTRIES))
        else $error("held count beyond pool");
    a_full_no_add: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_OUT && st_reg == ST_FULL) |-> $stable(cnt_reg))
        else $error("count moved on refused add");
    a_hit_port: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_OUT && req_reg != REQ_LOOKUP) |-> (pout_reg == '0))
        else $error("port set on non-lookup");
`endif

endmodule
`default_nettype wire

// ===== rtl/core/mac_vlan_exact_match_table_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mac_vlan_exact_match_table_top
// MAC+VLAN exact-match table with hash-chained buckets.
// ----------------------------------------------------------------------------
// Requests come in on s_axis (lookup, add, delete, clear) and each gives one
// result transfer on m_axis. One request is handled at a time.
// Lookup, add and delete take the bucket hash, one dividend bit per cycle,
// then read the bucket head and compare the first entry; each chain entry
// passed over adds a read and a compare, and a new add then reads a free slot
// and writes the entry there. A refused add and a clear go straight to the
// answer. Except after a clear, the next request is taken in the cycle after
// the result transfer. After reset and after a clear's result, the free-slot
// list is refilled, one slot per cycle, while s_axis_tready is low. The result
// stays in its output register until m_axis_tready is high; no new request
// is taken meanwhile. Configuration writes (cfg_we, cfg_addr, cfg_wdata) take
// effect at once; the user must make them only while idle; the block won't check.
// ----------------------------------------------------------------------------
module mac_vlan_exact_match_table_top
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // [47:0] mac_address, [59:48] vlan_number, [75:60] port_number, [79:76] zero
    input  wire logic [79:0] s_axis_tdata,
    // [1:0] req_type
    input  wire logic [1:0]  s_axis_tuser,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // [15:0] port_out, [26:16] stored_count, [31:27] zero
    output logic [31:0]      m_axis_tdata,
    // [1:0] status
    output logic [1:0]       m_axis_tuser,
    input  wire logic        cfg_we,
    input  wire logic        cfg_addr,
    input  wire logic [10:0] cfg_wdata
);
    import mvt_pkg::*;

    logic [DIV_W-1:0]  buckets_reg;
    logic [LIM_W-1:0]  limit_reg;
    mod_req_t          mreq;
    mod_rsp_t          mrsp;
    logic [PORT_W-1:0] rport;
    logic [CNT_W-1:0]  rcnt;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            buckets_reg <= DIV_W'(256);
            limit_reg   <= LIM_W'(1024);
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                CFG_BUCKETS: buckets_reg <= cfg_wdata[DIV_W-1:0];
                CFG_LIMIT:   limit_reg   <= cfg_wdata;
                default:     ;
            endcase
        end
    end

    mvt_mod u_mod
    (
        .clk (clk),
        .rst_n (rst_n),
        .req (mreq),
        .rsp (mrsp)
    );

    mvt_ctrl u_ctrl
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_axis_tvalid),
        .in_ready    (s_axis_tready),
        .in_req      (s_axis_tuser),
        .in_key      (s_axis_tdata[KEY_W-1:0]),
        .in_port     (s_axis_tdata[KEY_W+PORT_W-1:KEY_W]),
        .buckets_cfg (buckets_reg),
        .limit_cfg   (limit_reg),
        .mod_req     (mreq),
        .mod_rsp     (mrsp),
        .res_valid   (m_axis_tvalid),
        .res_ready   (m_axis_tready),
        .res_status  (m_axis_tuser),
        .res_port    (rport),
        .res_count   (rcnt)
    );

    assign m_axis_tdata = {5'd0, rcnt, rport};

endmodule
`default_nettype wire

// ===== test/tb_mac_vlan_exact_match_table_top.sv =====
// ----------------------------------------------------------------------------
// tb_mac_vlan_exact_match_table_top
// Self-checking bench for the MAC/VLAN exact-match table. Requests are pushed
// through s_axis from a queue. A local model of the hash-chained table
// predicts every answer at request acceptance. Answers taken from m_axis are
// compared field by field in order. Runs a directed part, then random phases
// under several bucket/limit settings, with random idling on both sides.
// ----------------------------------------------------------------------------
module tb_mac_vlan_exact_match_table_top;
    import mvt_pkg::*;

    localparam int NIL        = ENTRIES;
    localparam int DOG_LIMIT  = 20000;
    localparam int LONG_HOLD  = 300;
    localparam int DRAIN_WAIT = 1100;

    typedef struct packed {
        logic [1:0]  kind;
        logic [47:0] mac;
        logic [11:0] vlan;
        logic [15:0] port;
    } table_req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] port;
        logic [10:0] count;
    } table_answer_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [79:0] s_axis_tdata;
    logic [1:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;
    logic        cfg_we;
    logic        cfg_addr;
    logic [10:0] cfg_wdata;

    mac_vlan_exact_match_table_top dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata)
    );

    // Model state of the table
    logic [8:0]  mdl_buckets;
    logic [10:0] mdl_limit;
    int          mdl_heads [BUCKETS];
    logic [59:0] mdl_key   [ENTRIES];
    logic [15:0] mdl_port  [ENTRIES];
    int          mdl_next  [ENTRIES];
    int          mdl_free  [ENTRIES];
    int          mdl_held;

    table_req_t    req_q [$];
    table_answer_t answer_q [$];
    table_req_t    pool [$];

    int  errors;
    int  src_gap;
    int  sink_gap;
    int  dog_count;
    bit  calm;
    bit  long_hold_req;
    bit  long_hold_done;
    logic req_taken;

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        begin
            $display("mismatch %s: got %0d expected %0d (time %0t)", what, got, want, $time);
            errors++;
        end
    endtask

    task automatic empty_table();
        begin
            for (int i = 0; i < BUCKETS; i++) mdl_heads[i] = NIL;
            for (int i = 0; i < ENTRIES; i++) mdl_free[i] = i;
            mdl_held = 0;
        end
    endtask

    function automatic int bucket_index(input logic [47:0] mac, input logic [11:0] vlan);
        logic [47:0] mixed;
        int          div;
        begin
            mixed = mac ^ ({36'd0, vlan} << VLAN_SHIFT);
            div = mdl_buckets;
            if (div == 0) div = 1;
            if (div > BUCKETS) div = BUCKETS;
            bucket_index = int'(mixed % 48'(div));
        end
    endfunction

    // Walk one chain for a key; hit and prev are NIL when absent
    task automatic find_entry(input int bkt, input logic [59:0] key,
                              output int hit, output int prev);
        int cur;
        int steps;
        int last;
        begin
            cur = mdl_heads[bkt];
            last = NIL;
            hit = NIL;
            steps = 0;
            while (cur < NIL && steps < ENTRIES && hit == NIL) begin
                if (mdl_key[cur] == key) hit = cur;
                else
                begin
                    last = cur;
                    cur = mdl_next[cur];
                    steps++;
                end
            end
            prev = (hit == NIL) ? NIL : last;
        end
    endtask

    // Apply one request to the model and return the answer it gives
    task automatic predict_answer(input table_req_t r, output table_answer_t a);
        logic [59:0] key;
        int          bkt;
        int          hit;
        int          prev;
        int          lim;
        int          slot;
        begin
            key = {r.vlan, r.mac};
            bkt = bucket_index(r.mac, r.vlan);
            lim = (mdl_limit > ENTRIES) ? ENTRIES : mdl_limit;
            a.status = ST_OK;
            a.port = '0;
            case (r.kind)
                REQ_LOOKUP:
                begin
                    find_entry(bkt, key, hit, prev);
                    if (hit < NIL) a.port = mdl_port[hit];
                    else a.status = ST_MISS;
                end
                REQ_ADD:
                begin
                    if (mdl_held >= lim) a.status = ST_FULL;
                    else
                    begin
                        find_entry(bkt, key, hit, prev);
                        if (hit < NIL) mdl_port[hit] = r.port;
                        else
                        begin
                            slot = mdl_free[mdl_held] % ENTRIES;
                            mdl_key[slot] = key;
                            mdl_port[slot] = r.port;
                            mdl_next[slot] = mdl_heads[bkt];
                            mdl_heads[bkt] = slot;
                            mdl_held++;
                        end
                    end
                end
                REQ_DEL:
                begin
                    find_entry(bkt, key, hit, prev);
                    if (hit < NIL)
                    begin
                        if (prev < NIL) mdl_next[prev] = mdl_next[hit];
                        else mdl_heads[bkt] = mdl_next[hit];
                        if (mdl_held > 0)
                        begin
                            mdl_held--;
                            mdl_free[mdl_held] = hit;
                        end
                    end
                    else a.status = ST_MISS;
                end
                default: empty_table();
            endcase
            a.count = 11'(mdl_held);
        end
    endtask

    // Monitor: prediction on request transfers, check on answer transfers
    always @(posedge clk)
    begin
        table_req_t    r;
        table_answer_t a;
        table_answer_t want;
        if (rst_n)
        begin
            req_taken <= s_axis_tvalid && s_axis_tready;
            if (cfg_we)
            begin
                if (cfg_addr == CFG_BUCKETS) mdl_buckets = cfg_wdata[8:0];
                else mdl_limit = cfg_wdata;
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                r.kind = s_axis_tuser;
                r.mac  = s_axis_tdata[47:0];
                r.vlan = s_axis_tdata[59:48];
                r.port = s_axis_tdata[75:60];
                predict_answer(r, a);
                answer_q.push_back(a);
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (answer_q.size() == 0)
                begin
                    $display("mismatch: answer with nothing pending (time %0t)", $time);
                    errors++;
                end
                else
                begin
                    want = answer_q.pop_front();
                    if (m_axis_tuser != want.status)
                        report_mismatch("status", m_axis_tuser, want.status);
                    if (m_axis_tdata[15:0] != want.port)
                        report_mismatch("port_out", m_axis_tdata[15:0], want.port);
                    if (m_axis_tdata[26:16] != want.count)
                        report_mismatch("stored_count", m_axis_tdata[26:16], want.count);
                end
            end
            // watchdog on transfer activity
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                dog_count = 0;
            else
                dog_count++;
            if (dog_count >= DOG_LIMIT)
            begin
                $display("status: fail");
                $finish;
            end
        end
        else req_taken <= 1'b0;
    end

    // Request driver
    always @(negedge clk)
    begin
        table_req_t r;
        if (rst_n)
        begin
            if (s_axis_tvalid && !req_taken)
            begin
                // hold current transfer
            end
            else if (src_gap > 0)
            begin
                src_gap--;
                s_axis_tvalid <= 1'b0;
            end
            else if (req_q.size() > 0)
            begin
                r = req_q.pop_front();
                s_axis_tdata  <= {4'd0, r.port, r.vlan, r.mac};
                s_axis_tuser  <= r.kind;
                s_axis_tvalid <= 1'b1;
                if (!calm && $urandom_range(0, 7) == 0) src_gap = $urandom_range(1, 7);
            end
            else s_axis_tvalid <= 1'b0;
        end
    end

    // Answer receiver with random stalls and one long hold-off
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (sink_gap > 0)
            begin
                sink_gap--;
                m_axis_tready <= 1'b0;
            end
            else if (long_hold_req && !long_hold_done)
            begin
                long_hold_done = 1'b1;
                sink_gap = LONG_HOLD - 1;
                m_axis_tready <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 9) == 0)
            begin
                sink_gap = $urandom_range(0, 6);
                m_axis_tready <= 1'b0;
            end
            else m_axis_tready <= 1'b1;
        end
    end

    task automatic push_req(input logic [1:0] kind, input logic [47:0] mac,
                            input logic [11:0] vlan, input logic [15:0] port);
        table_req_t r;
        begin
            r.kind = kind;
            r.mac = mac;
            r.vlan = vlan;
            r.port = port;
            req_q.push_back(r);
        end
    endtask

    task automatic write_reg(input logic addr, input logic [10:0] value);
        begin
            @(negedge clk);
            cfg_we <= 1'b1;
            cfg_addr <= addr;
            cfg_wdata <= value;
            @(negedge clk);
            cfg_we <= 1'b0;
        end
    endtask

    // Wait until every request is answered, then let the block settle
    task automatic wait_drained();
        begin
            while (req_q.size() != 0 || s_axis_tvalid || answer_q.size() != 0)
                @(posedge clk);
            repeat (DRAIN_WAIT) @(posedge clk);
        end
    endtask

    // One random phase: mostly keys from a small pool so hits are common
    task automatic random_phase(input int n_items);
        table_req_t r;
        int         pool_size;
        int         pick;
        begin
            pool.delete();
            pool_size = $urandom_range(8, 48);
            for (int i = 0; i < pool_size; i++)
            begin
                if (i > 0 && $urandom_range(0, 4) == 0)
                    r.mac = pool[$urandom_range(0, i - 1)].mac;  // same MAC, other VLAN
                else
                    r.mac = 48'({$urandom, $urandom});
                r.vlan = 12'($urandom);
                pool.push_back(r);
            end
            for (int i = 0; i < n_items; i++)
            begin
                r = pool[$urandom_range(0, pool_size - 1)];
                if ($urandom_range(0, 6) == 0)
                begin
                    r.mac = 48'({$urandom, $urandom});
                    r.vlan = 12'($urandom);
                end
                pick = $urandom_range(0, 99);
                if (pick < 45) r.kind = REQ_ADD;
                else if (pick < 70) r.kind = REQ_LOOKUP;
                else if (pick < 98) r.kind = REQ_DEL;
                else r.kind = REQ_CLEAR;
                r.port = 16'($urandom);
                req_q.push_back(r);
            end
            wait_drained();
        end
    endtask

    // Main sequence
    initial
    begin
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = REQ_LOOKUP;
        m_axis_tready = 1'b0;
        cfg_we = 1'b0;
        cfg_addr = CFG_BUCKETS;
        cfg_wdata = '0;
        req_taken = 1'b0;
        errors = 0;
        src_gap = 0;
        sink_gap = 0;
        dog_count = 0;
        calm = 1'b0;
        long_hold_req = 1'b0;
        long_hold_done = 1'b0;
        mdl_buckets = 9'd256;
        mdl_limit = 11'd1024;
        empty_table();
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: field extremes, update, vlan in key, chain unlink, clear
        push_req(REQ_ADD,    48'h0, 12'h0, 16'hFFFF);
        push_req(REQ_ADD,    48'hFFFF_FFFF_FFFF, 12'hFFF, 16'h0);
        push_req(REQ_LOOKUP, 48'h0, 12'h0, 16'h0);
        push_req(REQ_LOOKUP, 48'hFFFF_FFFF_FFFF, 12'hFFF, 16'hFFFF);
        push_req(REQ_ADD,    48'h0, 12'h0, 16'h1234);
        push_req(REQ_LOOKUP, 48'h0, 12'h0, 16'h0);
        push_req(REQ_LOOKUP, 48'h0, 12'hFFF, 16'h0);
        push_req(REQ_ADD,    48'h0, 12'hFFF, 16'h0005);
        push_req(REQ_DEL,    48'h0, 12'h0, 16'h0);
        push_req(REQ_DEL,    48'h0, 12'h0, 16'h0);
        push_req(REQ_LOOKUP, 48'h0, 12'h0, 16'h0);
        push_req(REQ_LOOKUP, 48'h0, 12'hFFF, 16'h0);
        push_req(REQ_ADD,    48'h100, 12'h0, 16'h0001);
        push_req(REQ_ADD,    48'h200, 12'h0, 16'h0002);
        push_req(REQ_ADD,    48'h300, 12'h0, 16'h0003);
        push_req(REQ_DEL,    48'h200, 12'h0, 16'h0);
        push_req(REQ_LOOKUP, 48'h100, 12'h0, 16'h0);
        push_req(REQ_LOOKUP, 48'h300, 12'h0, 16'h0);
        push_req(REQ_DEL,    48'h100, 12'h0, 16'h0);
        push_req(REQ_CLEAR,  48'hFFFF_FFFF_FFFF, 12'hFFF, 16'hFFFF);
        push_req(REQ_LOOKUP, 48'h300, 12'h0, 16'h0);
        push_req(REQ_ADD,    48'h300, 12'h0, 16'h00AA);
        push_req(REQ_LOOKUP, 48'h300, 12'h0, 16'h0);
        wait_drained();

        // Random phases over bucket/limit settings, extremes included
        write_reg(CFG_BUCKETS, 11'd1);
        write_reg(CFG_LIMIT, 11'd12);
        random_phase(150);
        write_reg(CFG_BUCKETS, 11'd0);
        write_reg(CFG_LIMIT, 11'd6);
        long_hold_req = 1'b1;
        random_phase(150);
        write_reg(CFG_BUCKETS, 11'd511);
        write_reg(CFG_LIMIT, 11'd2047);
        random_phase(150);
        write_reg(CFG_BUCKETS, 11'd7);
        write_reg(CFG_LIMIT, 11'd0);
        random_phase(120);
        // bucket count changes with entries still held
        write_reg(CFG_LIMIT, 11'd30);
        random_phase(150);
        write_reg(CFG_BUCKETS, 11'd13);
        write_reg(CFG_LIMIT, 11'd1024);
        random_phase(150);
        write_reg(CFG_BUCKETS, 11'd256);
        random_phase(120);
        calm = 1'b1;
        random_phase(140);

        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/mvt_pkg.sv
rtl/core/mvt_mod.sv
rtl/core/mvt_ctrl.sv
rtl/core/mac_vlan_exact_match_table_top.sv
test/tb_mac_vlan_exact_match_table_top.sv
